/* rtl/blcd_pkg.sv */
package blcd_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] RegVoltageMargin  = 2'd0;
  localparam logic [1:0] RegSampleMargin   = 2'd1;
  localparam logic [1:0] RegChargingThresh = 2'd2;

  // register reset values
  localparam logic [9:0]  VoltageMarginRst  = 10'd20;
  localparam logic [7:0]  SampleMarginRst   = 8'd6;
  localparam logic [11:0] ChargingThreshRst = 12'd1000;

  // battery voltage is twice the divider reading minus the offset
  localparam logic [13:0] OffsetMv = 14'd50;

  // charge window, measured on twice the divider reading (2750+50 .. 4200+50)
  localparam logic [12:0] WinLowTwoAdc  = 13'd2800;
  localparam logic [12:0] WinHighTwoAdc = 13'd4250;
  localparam logic [10:0] SpanMv        = 11'd1450;

  // off*10000/1450 == off*200/29, done as off * (200*ceil(2^24/29)) >> 24
  localparam int unsigned PctShift = 24;
  localparam logic [26:0] PctMul   = 27'd115705000;

  localparam logic [7:0] JumpCountMax = 8'd255;

  typedef struct packed {
    logic [11:0] battery_adc_mv;
    logic [11:0] usb_adc_mv;
  } in_t;

  typedef struct packed {
    logic signed [13:0] battery_mv;
    logic [13:0]        percent_hundredths;
    logic               charging_now;
    logic               percent_changed;
    logic [13:0]        old_percent_hundredths;
    logic               charging_changed;
  } out_t;

  // classified poll as it sits in the queue
  typedef struct packed {
    logic signed [13:0] battery_mv;
    logic [13:0]        percent_hundredths;
    logic               charging_now;
  } item_t;

  typedef struct packed {
    logic [9:0]  voltage_margin_mv;
    logic [7:0]  sample_margin_count;
    logic [11:0] charging_threshold_mv;
  } cfg_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

/* rtl/battery_level_change_detector.sv */
// battery level change detector
//
// input channel: one beat per poll (in_valid_i / in_stall_o / in_data_i) with
// the calibrated battery divider and USB sense millivolts. output channel: one
// beat per poll (out_valid_o / out_stall_i / out_data_o) with battery voltage,
// charge level, charging state and the change flags.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 voltage margin, 1 sample margin, 2 charging threshold; index 3 ignored);
// write only while no poll is in flight.
// a front end computes voltage, level and charging per poll combinationally and
// writes it into a two-entry queue; the back end applies the stored-level
// tracking and loads the output register.
// an accepted beat is queued, then loaded into the output register once it is free.
// throughput: one poll per cycle while the output is not stalled, set by the back end update.
// when the receiver stalls the output beat holds, the queue takes up to two
// more polls, then in_stall_o rises until the output drains.
// reset: registers return to 20 / 6 / 1000, the stored level and counters
// clear, the queue empties and the next poll only primes the stored values.
module battery_level_change_detector (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  blcd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output blcd_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [11:0]     cfg_wdata_i
);

  blcd_pkg::cfg_t  cfg_q, cfg_d;
  blcd_pkg::item_t front_item;
  blcd_pkg::head_t head;
  logic            q_full;
  logic            pop;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        blcd_pkg::RegVoltageMargin:  cfg_d.voltage_margin_mv     = cfg_wdata_i[9:0];
        blcd_pkg::RegSampleMargin:   cfg_d.sample_margin_count   = cfg_wdata_i[7:0];
        blcd_pkg::RegChargingThresh: cfg_d.charging_threshold_mv = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_margin_mv     <= blcd_pkg::VoltageMarginRst;
      cfg_q.sample_margin_count   <= blcd_pkg::SampleMarginRst;
      cfg_q.charging_threshold_mv <= blcd_pkg::ChargingThreshRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  blcd_front u_front (
    .in_data_i               (in_data_i),
    .charging_threshold_mv_i (cfg_q.charging_threshold_mv),
    .item_o                  (front_item)
  );

  blcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (front_item),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  assign in_stall_o = q_full;

  blcd_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .head_i                (head),
    .pop_o                 (pop),
    .voltage_margin_mv_i   (cfg_q.voltage_margin_mv),
    .sample_margin_count_i (cfg_q.sample_margin_count),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_data_o            (out_data_o)
  );

endmodule

/* rtl/blcd_front.sv */
module blcd_front (
  input  blcd_pkg::in_t   in_data_i,
  input  logic [11:0]     charging_threshold_mv_i,
  output blcd_pkg::item_t item_o
);

  logic [12:0] two_adc;
  logic [13:0] mv_u;
  logic [10:0] off;
  logic [37:0] prod;

  // battery voltage
  assign two_adc = {in_data_i.battery_adc_mv, 1'b0};
  assign mv_u    = {1'b0, two_adc} - blcd_pkg::OffsetMv;

  // clamp into the charge window
  always_comb begin
    if (two_adc < blcd_pkg::WinLowTwoAdc) begin
      off = 11'd0;
    end else if (two_adc > blcd_pkg::WinHighTwoAdc) begin
      off = blcd_pkg::SpanMv;
    end else begin
      off = 11'(two_adc - blcd_pkg::WinLowTwoAdc);
    end
  end

  // scale to hundredths of a percent by reciprocal multiply
  assign prod = {27'd0, off} * {11'd0, blcd_pkg::PctMul};

  assign item_o.battery_mv         = $signed(mv_u);
  assign item_o.percent_hundredths = prod[blcd_pkg::PctShift +: 14];
  assign item_o.charging_now       = in_data_i.usb_adc_mv > charging_threshold_mv_i;

endmodule

/* rtl/blcd_queue.sv */
module blcd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  blcd_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output blcd_pkg::head_t head_o
);

  blcd_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != 2'd0);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o.valid = count_q != 2'd0;
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

/* rtl/blcd_back.sv */
module blcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blcd_pkg::head_t head_i,
  output logic            pop_o,
  input  logic [9:0]      voltage_margin_mv_i,
  input  logic [7:0]      sample_margin_count_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output blcd_pkg::out_t  out_data_o
);

  logic               primed_q, primed_d;
  logic signed [13:0] stored_mv_q, stored_mv_d;
  logic [13:0]        stored_pct_q, stored_pct_d;
  logic               stored_chg_q, stored_chg_d;
  logic [7:0]         jump_cnt_q, jump_cnt_d;
  logic               out_valid_q, out_valid_d;
  blcd_pkg::out_t     out_q, out_d;

  logic               take;
  logic signed [14:0] diff;
  logic [14:0]        diff_abs;
  logic               jump;
  logic               accept;
  blcd_pkg::item_t    it;

  assign it   = head_i.item;
  assign take = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = take;

  // jump detection against the stored level
  assign diff     = {it.battery_mv[13], it.battery_mv} - {stored_mv_q[13], stored_mv_q};
  assign diff_abs = diff[14] ? 15'(-diff) : 15'(diff);
  assign jump     = diff_abs > {5'd0, voltage_margin_mv_i};
  assign accept   = primed_q && jump && (jump_cnt_q > sample_margin_count_i);

  // state update and result for the beat at the queue head
  always_comb begin
    primed_d     = primed_q;
    stored_mv_d  = stored_mv_q;
    stored_pct_d = stored_pct_q;
    stored_chg_d = stored_chg_q;
    jump_cnt_d   = jump_cnt_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (take) begin
      out_valid_d                   = 1'b1;
      out_d.battery_mv              = it.battery_mv;
      out_d.percent_hundredths      = it.percent_hundredths;
      out_d.charging_now            = it.charging_now;
      out_d.percent_changed         = 1'b0;
      out_d.old_percent_hundredths  = 14'd0;
      out_d.charging_changed        = 1'b0;
      if (!primed_q) begin
        primed_d     = 1'b1;
        stored_mv_d  = it.battery_mv;
        stored_pct_d = it.percent_hundredths;
        stored_chg_d = it.charging_now;
      end else begin
        if (accept) begin
          out_d.old_percent_hundredths = stored_pct_q;
          out_d.percent_changed        = stored_pct_q != it.percent_hundredths;
          jump_cnt_d                   = 8'd0;
          stored_mv_d                  = it.battery_mv;
          stored_pct_d                 = it.percent_hundredths;
        end else if (jump && (jump_cnt_q != blcd_pkg::JumpCountMax)) begin
          jump_cnt_d = jump_cnt_q + 8'd1;
        end
        if (it.charging_now != stored_chg_q) begin
          out_d.charging_changed = 1'b1;
          stored_chg_d           = it.charging_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      stored_mv_q  <= 14'sd0;
      stored_pct_q <= 14'd0;
      stored_chg_q <= 1'b0;
      jump_cnt_q   <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      primed_q     <= primed_d;
      stored_mv_q  <= stored_mv_d;
      stored_pct_q <= stored_pct_d;
      stored_chg_q <= stored_chg_d;
      jump_cnt_q   <= jump_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/blcd_checker.sv */
module blcd_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input blcd_pkg::out_t  out_data_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed under stall");

  // a flagged level change reports a different previous level
  a_pct_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.percent_changed |->
      out_data_o.old_percent_hundredths != out_data_o.percent_hundredths)
    else $error("level change flagged with equal levels");

  // level stays within full scale
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.percent_hundredths <= 14'd10000)
    else $error("level above full scale");

  // battery voltage is always even
  a_mv_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.battery_mv[0])
    else $error("odd battery voltage");

endmodule

bind battery_level_change_detector blcd_checker u_blcd_checker (.*);
